// ----- rtl/core/sdrs_pkg.sv -----
`default_nettype none
package sdrs_pkg;

  // fixed item format
  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned GAIN_FRAC     = 16;

  typedef enum logic [2:0] {
    MODE_STEP   = 3'd0,
    MODE_PEEK   = 3'd1,
    MODE_PRESET = 3'd2,
    MODE_COOL   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAGS      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAINS      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CDDUR      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CDGAIN     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_VMAX       = 4'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd9;  // beyond the register list

  // fade quotient is below one, so 16 bits
  localparam int unsigned DIV_STEPS = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_KCOOL,
    ST_DIV,
    ST_KFADE,
    ST_KE,
    ST_DV,
    ST_VHI,
    ST_VLO,
    ST_POS,
    ST_CLAMP,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/core/sdrs_if.sv -----
`default_nettype none
interface sdrs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] time_step;
  logic signed [31:0] sample;
  logic signed [31:0] preset_value;
  logic [31:0] cooldown_request;
  modport source (output valid, mode, time_step, sample, preset_value, cooldown_request,
                  input ready);
  modport sink (input valid, mode, time_step, sample, preset_value, cooldown_request,
                output ready);
endinterface

interface sdrs_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] output_value;
  logic signed [31:0] velocity_now;
  logic [31:0] cooldown_left;
  logic        is_seeded;
  modport source (output valid, output_value, velocity_now, cooldown_left, is_seeded,
                  input ready);
  modport sink (input valid, output_value, velocity_now, cooldown_left, is_seeded,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/spring_damper_recovery_smoother.sv -----
// Spring-damper follower with jump recovery.
// Channels: in_if (sink) takes one item {mode, time_step, sample,
// preset_value, cooldown_request}; out_if (source) gives exactly one result
// item per input item. Configuration is a plain write port (cfg_we_i,
// cfg_idx_i, cfg_data_i), to be written only while no item is in work.
// Preset, cooldown, clear, unused modes and steps that do not integrate go
// from ST_PREP straight to ST_OUT; an integrating step or peek passes through
// ST_KE, ST_DV, ST_VHI, ST_VLO, ST_POS and ST_CLAMP, a running cooldown adds
// ST_KCOOL before them and the band fade adds ST_DIV and ST_KFADE. The fade
// uses a restoring divider (one quotient bit a cycle); seven products share
// one 34x25 signed multiplier, one product a cycle.
// in_if.ready is high only in idle, so one item is in work at a time and the
// next can be taken in the cycle after the result is registered.
// Reset clears position, speed, cooldown and the seeded flag and loads the
// register reset values.
// When the receiver stalls the result holds in the output register; the next
// item is still taken and worked, and waits in its last cycle until the
// register frees.
`default_nettype none
module spring_damper_recovery_smoother
  import sdrs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  sdrs_in_if.sink    in_if,
  sdrs_out_if.source out_if
);
  localparam logic signed [63:0] VAL_MAX  = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] VAL_MIN  = -VAL_MAX - 64'sd1;
  localparam logic [16:0]        GAIN_ONE = 17'd65536;

  // registers
  logic [3:0]  flags_q;
  logic [47:0] gains_q;
  logic [30:0] band_q, thr_q, vmax_q;
  logic [31:0] cddur_q;
  logic [16:0] cdgain_q;
  logic [63:0] clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= 4'd1;
      gains_q  <= 48'h010000010000;
      band_q   <= '0;
      thr_q    <= 31'h7FFFFFFF;
      cddur_q  <= '0;
      cdgain_q <= 17'd32768;
      clamp_q  <= 64'h7FFFFFFF80000000;
      vmax_q   <= 31'h7FFFFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLAGS:  flags_q  <= cfg_data_i[3:0];
        CFG_GAINS:  gains_q  <= cfg_data_i[47:0];
        CFG_BAND:   band_q   <= cfg_data_i[30:0];
        CFG_THRESH: thr_q    <= cfg_data_i[30:0];
        CFG_CDDUR:  cddur_q  <= cfg_data_i[31:0];
        CFG_CDGAIN: cdgain_q <= cfg_data_i[16:0];
        CFG_CLAMP:  clamp_q  <= cfg_data_i;
        CFG_VMAX:   vmax_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // architectural state
  logic signed [31:0] pos_q, spd_q;
  logic [31:0] cd_q;
  logic        seed_q;

  // item in work
  state_e st_q, st_d;
  logic [2:0]  mode_q;
  logic [15:0] dt_q;
  logic signed [31:0] x_q, pre_q;
  logic [31:0] req_q;

  // working copy of the state
  logic signed [31:0] wpos_q, wspd_q;
  logic [31:0] wcd_q;
  logic        wseed_q;

  // integration datapath
  logic signed [32:0] e_q;
  logic [23:0] k_q;
  logic        fade_q;
  logic [30:0] rem_q;
  logic [15:0] quo_q;
  logic [3:0]  cnt_q;
  logic signed [63:0] acc_q, v_q;
  logic signed [31:0] y_q;

  // output register
  logic        ov_q;
  logic signed [31:0] o_val_q, o_spd_q;
  logic [31:0] o_cd_q;
  logic        o_seed_q;

  logic acc_in, acc_out, out_free;

  assign in_if.ready = (st_q == ST_IDLE);
  assign acc_in      = in_if.valid && in_if.ready;
  assign acc_out     = ov_q && out_if.ready;
  assign out_free    = !ov_q || out_if.ready;

  assign out_if.valid         = ov_q;
  assign out_if.output_value  = o_val_q;
  assign out_if.velocity_now  = o_spd_q;
  assign out_if.cooldown_left = o_cd_q;
  assign out_if.is_seeded     = o_seed_q;

  // mode handling, seeding and jump detection, from the latched item
  logic signed [31:0] prep_pos, prep_spd;
  logic [31:0]        prep_cd;
  logic               prep_seed, prep_run, prep_fade;
  logic signed [32:0] prep_e;
  logic [32:0]        prep_ae;

  always_comb begin
    prep_pos  = pos_q;
    prep_spd  = spd_q;
    prep_cd   = cd_q;
    prep_seed = seed_q;
    prep_run  = 1'b0;
    // error against the position integration would start from
    prep_e    = 33'(x_q) - 33'(seed_q ? pos_q : 32'sd0);
    prep_ae   = prep_e[32] ? 33'(-prep_e) : 33'(prep_e);
    prep_fade = (band_q != 31'd0) && (prep_ae < {2'b00, band_q});
    unique case (mode_q)
      MODE_STEP, MODE_PEEK: begin
        if (!flags_q[0]) begin
          // disabled: pass-through
          prep_pos = x_q; prep_spd = '0; prep_cd = '0; prep_seed = 1'b1;
        end else if (flags_q[1]) begin
          prep_pos = '0; prep_spd = '0; prep_cd = '0; prep_seed = 1'b1;
        end else if (!seed_q && flags_q[3]) begin
          // snap on the first sample
          prep_pos = x_q; prep_spd = '0; prep_cd = '0; prep_seed = 1'b1;
        end else begin
          if (!seed_q) begin
            prep_pos = '0; prep_spd = '0; prep_cd = '0;
          end
          prep_seed = 1'b1;
          if (prep_ae > {2'b00, thr_q} && prep_cd < cddur_q) prep_cd = cddur_q;
          prep_run = (dt_q != 16'd0);
        end
      end
      MODE_PRESET: begin
        prep_pos = pre_q; prep_spd = '0; prep_cd = '0; prep_seed = 1'b1;
      end
      MODE_COOL: begin
        if (cd_q < req_q) prep_cd = req_q;
      end
      MODE_CLEAR: begin
        prep_pos = '0; prep_spd = '0; prep_cd = '0; prep_seed = 1'b0;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (acc_in) st_d = ST_PREP;
      ST_PREP: begin
        if (!prep_run) st_d = ST_OUT;
        else if (prep_cd != 32'd0) st_d = ST_KCOOL;
        else if (prep_fade) st_d = ST_DIV;
        else st_d = ST_KE;
      end
      ST_KCOOL: st_d = fade_q ? ST_DIV : ST_KE;
      ST_DIV:   if (cnt_q == 4'(DIV_STEPS - 1)) st_d = ST_KFADE;
      ST_KFADE: st_d = ST_KE;
      ST_KE:    st_d = ST_DV;
      ST_DV:    st_d = ST_VHI;
      ST_VHI:   st_d = ST_VLO;
      ST_VLO:   st_d = ST_POS;
      ST_POS:   st_d = ST_CLAMP;
      ST_CLAMP: st_d = ST_OUT;
      ST_OUT:   if (out_free) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // shared multiplier, operands picked by state
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] mul_p;
  logic signed [63:0] mul_w;
  logic [16:0]        gain_sat;

  always_comb begin
    gain_sat = (cdgain_q > GAIN_ONE) ? GAIN_ONE : cdgain_q;
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      ST_KCOOL: begin mul_a = {10'd0, k_q}; mul_b = {8'd0, gain_sat}; end
      ST_KFADE: begin mul_a = {10'd0, k_q}; mul_b = {9'd0, quo_q}; end
      ST_KE:    begin mul_a = {e_q[32], e_q}; mul_b = {1'b0, k_q}; end
      ST_DV: begin
        mul_a = {{2{wspd_q[31]}}, wspd_q};
        mul_b = {1'b0, gains_q[47:24]};
      end
      // accel * dt split at bit 16: upper part exact, lower part floored
      ST_VHI:   begin mul_a = acc_q[49:16]; mul_b = {9'd0, dt_q}; end
      ST_VLO:   begin mul_a = {18'd0, acc_q[15:0]}; mul_b = {9'd0, dt_q}; end
      ST_POS:   begin mul_a = {{2{v_q[31]}}, v_q[31:0]}; mul_b = {9'd0, dt_q}; end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
    mul_w = 64'(mul_p);
  end

  // velocity cap and position sum
  logic signed [63:0] vlim, vsum, ysum;
  always_comb begin
    vlim = (vmax_q == 31'd0) ? 64'sd1 : {33'd0, vmax_q};
    vsum = v_q + (mul_w >>> FRACTION_BITS);
    ysum = 64'(wpos_q) + (mul_w >>> FRACTION_BITS);
  end

  // clamp window, limits put in order
  logic signed [31:0] win_a, win_b, lo, hi, y_cl, v_cl;
  always_comb begin
    win_a = clamp_q[31:0];
    win_b = clamp_q[63:32];
    lo    = (win_a > win_b) ? win_b : win_a;
    hi    = (win_a > win_b) ? win_a : win_b;
    y_cl  = y_q;
    v_cl  = v_q[31:0];
    if (flags_q[2]) begin
      if (y_cl < lo) y_cl = lo;
      if (y_cl > hi) y_cl = hi;
      if (y_cl <= lo && v_cl < 0) v_cl = '0;
      if (y_cl >= hi && v_cl > 0) v_cl = '0;
    end
  end

  // restoring division step for the fade
  logic [31:0] div_sh, div_diff;
  logic        div_sub;
  assign div_sh   = {rem_q, 1'b0};
  assign div_sub  = (div_sh >= {1'b0, band_q});
  assign div_diff = div_sh - {1'b0, band_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      pos_q  <= '0; spd_q <= '0; cd_q <= '0; seed_q <= 1'b0;
      mode_q <= '0; dt_q <= '0; x_q <= '0; pre_q <= '0; req_q <= '0;
      wpos_q <= '0; wspd_q <= '0; wcd_q <= '0; wseed_q <= 1'b0;
      e_q    <= '0; k_q <= '0; fade_q <= 1'b0;
      rem_q  <= '0; quo_q <= '0; cnt_q <= '0;
      acc_q  <= '0; v_q <= '0; y_q <= '0;
      o_val_q <= '0; o_spd_q <= '0; o_cd_q <= '0; o_seed_q <= 1'b0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        ST_IDLE: if (acc_in) begin
          mode_q <= in_if.mode;
          dt_q   <= in_if.time_step;
          x_q    <= in_if.sample;
          pre_q  <= in_if.preset_value;
          req_q  <= in_if.cooldown_request;
        end
        ST_PREP: begin
          wpos_q  <= prep_pos;
          wspd_q  <= prep_spd;
          wcd_q   <= prep_cd;
          wseed_q <= prep_seed;
          e_q     <= prep_e;
          k_q     <= gains_q[23:0];
          fade_q  <= prep_fade;
          rem_q   <= prep_ae[30:0];  // below the band whenever the divider runs
          quo_q   <= '0;
          cnt_q   <= '0;
        end
        ST_KCOOL: begin
          k_q   <= mul_p[39:16];
          wcd_q <= (wcd_q > 32'(dt_q)) ? wcd_q - 32'(dt_q) : 32'd0;
        end
        ST_DIV: begin
          rem_q <= div_sub ? div_diff[30:0] : div_sh[30:0];
          quo_q <= {quo_q[14:0], div_sub};
          cnt_q <= cnt_q + 4'd1;
        end
        ST_KFADE: k_q <= mul_p[39:16];
        ST_KE:    acc_q <= mul_w;
        ST_DV:    acc_q <= (acc_q - mul_w) >>> FRACTION_BITS;
        ST_VHI:   v_q <= 64'(wspd_q) + mul_w;
        ST_VLO:   v_q <= (vsum > vlim) ? vlim : ((vsum < -vlim) ? -vlim : vsum);
        ST_POS: begin
          y_q <= (ysum > VAL_MAX) ? 32'(VAL_MAX)
               : ((ysum < VAL_MIN) ? 32'(VAL_MIN) : ysum[31:0]);
        end
        ST_CLAMP: begin
          wpos_q <= y_cl;
          wspd_q <= v_cl;
        end
        ST_OUT: if (out_free) begin
          o_val_q <= wpos_q;
          if (mode_q == MODE_PEEK) begin
            // peek leaves the state alone
            o_spd_q <= spd_q; o_cd_q <= cd_q; o_seed_q <= seed_q;
          end else begin
            pos_q <= wpos_q; spd_q <= wspd_q; cd_q <= wcd_q; seed_q <= wseed_q;
            o_spd_q <= wspd_q; o_cd_q <= wcd_q; o_seed_q <= wseed_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (st_q == ST_OUT && out_free) ov_q <= 1'b1;
    else if (acc_out) ov_q <= 1'b0;
  end

  out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.output_value)
      && $stable(out_if.velocity_now) && $stable(out_if.cooldown_left)))
    else $error("result changed while stalled");
  div_needs_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> fade_q)
    else $error("divider running outside the band");
  vel_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_POS) |-> (v_q <= vlim && v_q >= -vlim))
    else $error("velocity above cap");
endmodule
`default_nettype wire

// ----- sim/sdrs_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module sdrs_checker
  import sdrs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  sdrs_in_if.sink    in_mon,
  sdrs_out_if.sink   out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] vel;
    logic [31:0]        cool;
    logic               seeded;
  } result_t;

  typedef struct {
    longint pos;
    longint spd;
    logic [31:0] cd;
    bit seeded;
  } track_t;

  logic [3:0]  flags_q;
  logic [47:0] gains_q;
  logic [30:0] band_q, thresh_q, vmax_q;
  logic [31:0] cddur_q;
  logic [16:0] cdgain_q;
  logic [63:0] window_q;
  track_t      now_q;
  result_t     due_q[$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = due_q.size();

  function automatic longint fl16(longint x);
    return x >>> 16;  // arithmetic shift is a floor
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic track_t follow(track_t s, logic [15:0] dt, longint x);
    longint e, ae, k, d, accel, v, y, vm, lo, hi, tmp;
    longint unsigned g, fade;
    if (!flags_q[0]) begin
      s.pos = x; s.spd = 0; s.cd = 0; s.seeded = 1;
      return s;
    end
    if (flags_q[1]) begin
      s.pos = 0; s.spd = 0; s.cd = 0; s.seeded = 1;
      return s;
    end
    if (!s.seeded) begin
      s.seeded = 1; s.spd = 0; s.cd = 0;
      if (flags_q[3]) begin
        s.pos = x;
        return s;
      end
      s.pos = 0;
    end
    e = x - s.pos;
    ae = e < 0 ? -e : e;
    if (ae > longint'(thresh_q) && s.cd < cddur_q) s.cd = cddur_q;
    if (dt == 0) return s;
    k = longint'(gains_q[23:0]);
    d = longint'(gains_q[47:24]);
    if (s.cd > 0) begin
      g = cdgain_q > 17'd65536 ? 65536 : cdgain_q;
      k = longint'((longint'(k) * g) >> 16);
      s.cd = s.cd > dt ? s.cd - dt : 0;
    end
    if (band_q != 0 && ae < longint'(band_q)) begin
      fade = (longint'(ae) << 16) / longint'(band_q);
      k = longint'((longint'(k) * fade) >> 16);
    end
    accel = fl16(k * e - d * s.spd);
    v = s.spd + fl16(accel * longint'(dt));
    vm = longint'(vmax_q);
    if (vm < 1) vm = 1;
    if (v > vm) v = vm;
    if (v < -vm) v = -vm;
    y = sat32(s.pos + fl16(v * longint'(dt)));
    if (flags_q[2]) begin
      lo = longint'(signed'(window_q[31:0]));
      hi = longint'(signed'(window_q[63:32]));
      if (lo > hi) begin
        tmp = lo; lo = hi; hi = tmp;
      end
      if (y < lo) y = lo;
      if (y > hi) y = hi;
      if (y <= lo && v < 0) v = 0;
      if (y >= hi && v > 0) v = 0;
    end
    s.spd = v;
    s.pos = y;
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    track_t  sim;
    result_t r;
    result_t got;
    if (!rst_ni) begin
      flags_q  <= 4'd1;
      gains_q  <= 48'h010000010000;
      band_q   <= '0;
      thresh_q <= 31'h7FFFFFFF;
      cddur_q  <= '0;
      cdgain_q <= 17'd32768;
      window_q <= 64'h7FFFFFFF80000000;
      vmax_q   <= 31'h7FFFFFFF;
      now_q    <= '{0, 0, 0, 0};
      fails    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FLAGS:  flags_q  <= cfg_data_i[3:0];
          CFG_GAINS:  gains_q  <= cfg_data_i[47:0];
          CFG_BAND:   band_q   <= cfg_data_i[30:0];
          CFG_THRESH: thresh_q <= cfg_data_i[30:0];
          CFG_CDDUR:  cddur_q  <= cfg_data_i[31:0];
          CFG_CDGAIN: cdgain_q <= cfg_data_i[16:0];
          CFG_CLAMP:  window_q <= cfg_data_i;
          CFG_VMAX:   vmax_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        sim = now_q;
        case (in_mon.mode)
          MODE_STEP: sim = follow(sim, in_mon.time_step, longint'(in_mon.sample));
          MODE_PRESET: begin
            sim = '{longint'(in_mon.preset_value), 0, 0, 1};
          end
          MODE_COOL: if (sim.cd < in_mon.cooldown_request) sim.cd = in_mon.cooldown_request;
          MODE_CLEAR: sim = '{0, 0, 0, 0};
          default: ;
        endcase
        if (in_mon.mode == MODE_PEEK) begin
          sim = follow(now_q, in_mon.time_step, longint'(in_mon.sample));
          r = '{sim.pos[31:0], now_q.spd[31:0], now_q.cd, now_q.seeded};
        end else begin
          r = '{sim.pos[31:0], sim.spd[31:0], sim.cd, sim.seeded};
          now_q <= sim;
        end
        due_q.push_back(r);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.output_value, out_mon.velocity_now, out_mon.cooldown_left,
                out_mon.is_seeded};
        if (due_q.size() == 0) begin
          $error("unexpected result item");
          fails <= fails + 1;
        end else begin
          r = due_q.pop_front();
          if (got !== r) begin
            fails <= fails + 1;
            if (got.value !== r.value)
              $error("output_value exp %0d got %0d", r.value, got.value);
            if (got.vel !== r.vel)
              $error("velocity_now exp %0d got %0d", r.vel, got.vel);
            if (got.cool !== r.cool)
              $error("cooldown_left exp %0d got %0d", r.cool, got.cool);
            if (got.seeded !== r.seeded)
              $error("is_seeded exp %0d got %0d", r.seeded, got.seeded);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import sdrs_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int unsigned fail_count, pending, items_sent, settings_run;

  sdrs_in_if  in_if ();
  sdrs_out_if out_if ();

  spring_damper_recovery_smoother dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  sdrs_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_mon(in_if.sink), .out_mon(out_if.sink),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // generous hard limit on run time: about 1000 items with the longest gaps
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // receiver: ready wobbles independently of the sender
  initial begin
    int unsigned g;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (g == 0) out_if.ready = 1'b1;
      else begin
        out_if.ready = 1'b0;
        repeat (g) @(negedge clk_i);
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // drain all results, then let the block settle before touching registers
  task automatic wait_idle();
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic send_item(input logic [2:0] m, input logic [15:0] dt,
                           input logic [31:0] smp, input logic [31:0] pre,
                           input logic [31:0] req);
    int unsigned g;
    g = gap_len();
    if (g != 0) repeat (g) @(negedge clk_i);
    in_if.valid            = 1'b1;
    in_if.mode             = m;
    in_if.time_step        = dt;
    in_if.sample           = smp;
    in_if.preset_value     = pre;
    in_if.cooldown_request = req;
    // ready only moves at the rising edge, so it is settled here
    while (!in_if.ready) @(negedge clk_i);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    items_sent++;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 8000))) :
                                       -32'(int'($urandom_range(0, 8000)));
      default: return $urandom();
    endcase
  endfunction

  // random register setting; extremes turn up often
  task automatic random_setting();
    logic [63:0] w;
    cfg_write(CFG_FLAGS, 64'($urandom_range(0, 15)));
    case ($urandom_range(0, 2))
      0: cfg_write(CFG_GAINS, 64'hFFFFFFFFFFFF);
      1: cfg_write(CFG_GAINS, {$urandom(), $urandom()} & 64'hFFFFFFFFFFFF);
      default: cfg_write(CFG_GAINS, {16'b0, 24'($urandom_range(0, 131072)),
                                     24'($urandom_range(0, 131072))});
    endcase
    cfg_write(CFG_BAND, $urandom_range(0, 1) ? 64'($urandom() >> 1) :
                        64'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 1 << 20)));
    cfg_write(CFG_THRESH, $urandom_range(0, 1) ? 64'($urandom_range(0, 1 << 22)) :
                          64'($urandom() >> 1));
    cfg_write(CFG_CDDUR, $urandom_range(0, 3) == 0 ? 64'hFFFFFFFF :
                         64'($urandom_range(0, 1 << 18)));
    cfg_write(CFG_CDGAIN, 64'($urandom_range(0, 131071)));
    w = {$urandom(), $urandom()};
    cfg_write(CFG_CLAMP, w);
    cfg_write(CFG_VMAX, $urandom_range(0, 4) == 0 ? 64'($urandom_range(0, 2)) :
                        64'($urandom() >> 1));
    cfg_write(CFG_UNUSED_IDX, {$urandom(), $urandom()});  // ignored
  endtask

  initial begin
    logic [2:0] m;
    int unsigned r;
    in_if.valid = 1'b0;
    in_if.mode = MODE_STEP;
    in_if.time_step = '0;
    in_if.sample = '0;
    in_if.preset_value = '0;
    in_if.cooldown_request = '0;
    items_sent = 0;
    settings_run = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset setting, then extremes and every mode
    send_item(MODE_PEEK, 16'd100, 32'h00010000, 0, 0);
    send_item(MODE_STEP, 16'd0, 32'h7FFFFFFF, 0, 0);      // first sample, no snap
    send_item(MODE_STEP, 16'hFFFF, 32'h7FFFFFFF, 0, 0);
    send_item(MODE_STEP, 16'hFFFF, 32'h80000000, 0, 0);
    send_item(MODE_COOL, 16'd1, 0, 0, 32'hFFFFFFFF);
    send_item(MODE_STEP, 16'd1000, 32'h00050000, 0, 0);   // stiffness scaled in cooldown
    send_item(MODE_PRESET, 16'd0, 0, 32'h80000000, 0);
    send_item(MODE_STEP, 16'hFFFF, 32'h7FFFFFFF, 0, 0);
    send_item(3'd5, 16'd9, 32'h1234, 0, 0);               // unused modes change nothing
    send_item(3'd6, 16'd9, 32'h1234, 0, 0);
    send_item(3'd7, 16'd9, 32'h1234, 0, 0);
    send_item(MODE_CLEAR, 16'd3, 0, 0, 0);
    wait_idle();
    // snap, clamp with a reversed window, tiny vmax, gain above one, band fade
    cfg_write(CFG_FLAGS, 64'hF & ~64'h2);
    cfg_write(CFG_CLAMP, {32'hFFF00000, 32'h00100000});
    cfg_write(CFG_VMAX, 64'd0);
    cfg_write(CFG_CDGAIN, 64'h1FFFF);
    cfg_write(CFG_BAND, 64'h00080000);
    cfg_write(CFG_THRESH, 64'd0);
    cfg_write(CFG_CDDUR, 64'd500);
    cfg_write(CFG_GAINS, 64'hFFFFFFFFFFFF);
    send_item(MODE_STEP, 16'd10, 32'h00400000, 0, 0);     // snap on first sample
    send_item(MODE_STEP, 16'd10, 32'hFF000000, 0, 0);
    send_item(MODE_STEP, 16'hFFFF, 32'h00020000, 0, 0);
    send_item(MODE_PEEK, 16'hFFFF, 32'hFFFF0000, 0, 0);
    wait_idle();
    cfg_write(CFG_CLAMP, {32'h00030000, 32'h00030000});   // equal limits
    cfg_write(CFG_VMAX, 64'h7FFFFFFF);
    send_item(MODE_STEP, 16'd200, 32'h00100000, 0, 0);
    send_item(MODE_STEP, 16'd200, 32'hFFF00000, 0, 0);
    wait_idle();
    cfg_write(CFG_FLAGS, 64'h3);                          // force zero output
    send_item(MODE_STEP, 16'd5, 32'h00100000, 0, 0);
    wait_idle();
    cfg_write(CFG_FLAGS, 64'h0);                          // disabled: pass-through
    send_item(MODE_STEP, 16'd5, 32'h80000000, 0, 0);
    send_item(MODE_PEEK, 16'd5, 32'h7FFFFFFF, 0, 0);

    // random phases; each one holds a fresh setting
    while (items_sent < 950) begin
      wait_idle();
      random_setting();
      settings_run++;
      repeat (60) begin
        r = $urandom_range(0, 99);
        if (r < 62) m = MODE_STEP;
        else if (r < 74) m = MODE_PEEK;
        else if (r < 82) m = MODE_PRESET;
        else if (r < 90) m = MODE_COOL;
        else if (r < 96) m = MODE_CLEAR;
        else m = 3'($urandom_range(5, 7));
        send_item(m, $urandom_range(0, 7) == 0 ? 16'd0 :
                     ($urandom_range(0, 5) == 0 ? 16'($urandom()) : 16'($urandom_range(1, 4000))),
                  rand_val(), rand_val(),
                  $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 5000));
      end
    end

    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("Ran %0d items over %0d random register settings plus directed cases,",
             items_sent, settings_run);
    $display("all five modes, unused modes, clamp, snap, fade and cooldown paths.");
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/sdrs_pkg.sv
rtl/core/sdrs_if.sv
rtl/core/spring_damper_recovery_smoother.sv
sim/sdrs_checker.sv
sim/testbench.sv
